>>> design/base61_word_encoder_core_defines.svh
// Assertion macros shared by the encoder RTL.
// Each macro expects clk and rst_n in scope.
`ifndef BASE61_WORD_ENCODER_CORE_DEFINES_SVH
`define BASE61_WORD_ENCODER_CORE_DEFINES_SVH

// Condition that must hold at every clock edge out of reset
`define B61E_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication
`define B61E_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define B61E_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/b61e_pkg.sv
`default_nettype none

package b61e_pkg;

    localparam int WORD_W     = 64;
    localparam int CHUNK_W    = 16;
    localparam int NUM_CELLS  = WORD_W / CHUNK_W;
    localparam int RADIX      = 61;
    localparam int DIG_W      = 6;
    localparam int CHAR_W     = 8;
    localparam int MAX_DIGITS = 11;
    localparam int DCNT_W     = $clog2(MAX_DIGITS + 1);

    // Reciprocal of the radix, scaled by 2^RECIP_SHIFT and rounded up
    localparam int RECIP_SHIFT = 32;
    localparam int RECIP_W     = 27;
    localparam logic [63:0] RECIP_WIDE = ((64'd1 << RECIP_SHIFT) + 64'(RADIX) - 64'd1) / 64'(RADIX);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_WIDE[RECIP_W-1:0];

    // Default queue depths
    localparam int FRONT_DEPTH_DEF = 2;
    localparam int OUT_DEPTH_DEF   = 4;

    typedef enum logic [1:0] {
        SIZE_8B  = 2'd0,
        SIZE_4B  = 2'd1,
        SIZE_2B  = 2'd2,
        SIZE_BAD = 2'd3
    } size_code_t;

    // Classified word waiting for the digit engine
    typedef struct packed {
        logic [WORD_W-1:0] value;
        logic [DCNT_W-1:0] ndig;
    } item_t;

    // Partial remainder travelling down the cell chain
    typedef struct packed {
        logic             vld;
        logic             last;
        logic [DIG_W-1:0] rem;
    } tok_t;

    // Result queue entry
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } out_entry_t;

    localparam logic [CHAR_W-1:0] ALPHABET [RADIX] = '{
        "y", "7", "k", "X", "V", "0", "5", "J", "F", "p", "H", "z", "R", "L", "4", "8",
        "Q", "Y", "m", "b", "h", "S", "j", "u", "f", "B", "2", "W", "s", "D", "1", "e",
        "n", "9", "M", "T", "g", "P", "C", "x", "w", "K", "l", "d", "q", "t", "6", "E",
        "O", "U", "I", "A", "N", "a", "3", "G", "v", "i", "r", "c", "o"
    };

    // Map one digit to its character
    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIG_W-1:0] digit);
        logic [CHAR_W-1:0] ch;
        ch = '0;
        if (digit < DIG_W'(RADIX))
        begin
            ch = ALPHABET[digit];
        end
        return ch;
    endfunction

endpackage

`default_nettype wire

>>> design/base61_word_encoder_core.sv
// Channel   Direction  Handshake        Payload
// input     in         push / full      word_value[63:0], size_code[1:0]
// result    out        empty / pop      out_char[7:0], last_char
//
// A word of n digits (11, 6 or 3) occupies the digit engine for a load, n
// issues, four cells of chunk-wise division by 61 and a drain check; once
// filled, it emits one character per cycle while the result queue has room.
// Reset clears the queues and the sequencer; no clearing pass is needed.
// A full result queue freezes the cell chain; the input queue keeps taking
// words until it fills. Size code 3 is accepted and produces no result.
`default_nettype none

module base61_word_encoder_core #(
    parameter int FRONT_DEPTH = b61e_pkg::FRONT_DEPTH_DEF,
    parameter int OUT_DEPTH   = b61e_pkg::OUT_DEPTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           push,
    output logic                                full,
    input  wire logic [b61e_pkg::WORD_W-1:0]    word_value,
    input  wire logic [1:0]                     size_code,
    output logic                                empty,
    input  wire logic                           pop,
    output logic [b61e_pkg::CHAR_W-1:0]         out_char,
    output logic                                last_char
);

    logic            item_valid;
    logic            item_pop;
    b61e_pkg::item_t item;

    // Accept and classify words
    b61e_front #(
        .DEPTH (FRONT_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .word_value (word_value),
        .size_code  (size_code),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop)
    );

    // Produce digits and characters
    b61e_back #(
        .OUT_DEPTH (OUT_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop),
        .empty      (empty),
        .pop        (pop),
        .out_char   (out_char),
        .last_char  (last_char)
    );

endmodule

`default_nettype wire

>>> design/b61e_front.sv
`default_nettype none

`include "base61_word_encoder_core_defines.svh"

module b61e_front #(
    parameter int DEPTH = b61e_pkg::FRONT_DEPTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           push,
    output logic                                full,
    input  wire logic [b61e_pkg::WORD_W-1:0]    word_value,
    input  wire logic [1:0]                     size_code,
    output logic                                item_valid,
    output b61e_pkg::item_t                     item,
    input  wire logic                           item_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    b61e_pkg::item_t   mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    b61e_pkg::item_t   in_item;
    logic              in_ok;
    logic              wr_en;
    logic              rd_en;

    // Classify the incoming transaction: digit count and masked value
    always_comb
    begin
        in_item.value = word_value;
        in_item.ndig  = b61e_pkg::DCNT_W'(11);
        in_ok         = 1'b1;
        case (b61e_pkg::size_code_t'(size_code))
            b61e_pkg::SIZE_8B:
            begin
                in_item.ndig = b61e_pkg::DCNT_W'(11);
            end
            b61e_pkg::SIZE_4B:
            begin
                in_item.value = {32'b0, word_value[31:0]};
                in_item.ndig  = b61e_pkg::DCNT_W'(6);
            end
            b61e_pkg::SIZE_2B:
            begin
                in_item.value = {48'b0, word_value[15:0]};
                in_item.ndig  = b61e_pkg::DCNT_W'(3);
            end
            default:
            begin
                // Unused size code: drop the transaction
                in_ok = 1'b0;
            end
        endcase
    end

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign item_valid = (count_reg != '0);
    assign item       = mem_reg[rd_ptr_reg];
    assign wr_en      = push && !full && in_ok;
    assign rd_en      = item_pop && item_valid;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold queued words
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

    `B61E_ASSERT_ALWAYS(a_front_count_bound, count_reg <= CNT_W'(DEPTH),
        "front queue overflow")
    `B61E_ASSERT_NEXT(a_front_bad_size_dropped,
        push && !full && !rd_en && size_code == b61e_pkg::SIZE_BAD,
        count_reg == $past(count_reg), "unused size code was queued")
    `B61E_ASSERT_IMPL(a_front_no_pop_empty, item_pop, item_valid,
        "pop from empty front queue")

endmodule

`default_nettype wire

>>> design/b61e_cell.sv
`default_nettype none

module b61e_cell (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           advance,
    input  wire logic                           load,
    input  wire logic [b61e_pkg::CHUNK_W-1:0]   load_chunk,
    input  wire b61e_pkg::tok_t                 tok_in,
    output b61e_pkg::tok_t                      tok_out
);

    localparam int X_W = b61e_pkg::DIG_W + b61e_pkg::CHUNK_W;
    localparam int P_W = X_W + b61e_pkg::RECIP_W;

    logic [b61e_pkg::CHUNK_W-1:0] chunk_reg;
    logic                         vld_reg;
    logic                         last_reg;
    logic [b61e_pkg::DIG_W-1:0]   rem_reg;

    logic [X_W-1:0]                x;
    logic [P_W-1:0]                prod;
    logic [b61e_pkg::CHUNK_W-1:0]  quo;
    logic [X_W-1:0]                quo_x;
    logic [X_W-1:0]                quo61;
    logic [X_W-1:0]                rem_x;

    // One long-division step of this chunk by the radix
    always_comb
    begin
        x     = {tok_in.rem, chunk_reg};
        prod  = P_W'(x) * P_W'(b61e_pkg::RECIP);
        quo   = prod[b61e_pkg::RECIP_SHIFT +: b61e_pkg::CHUNK_W];
        quo_x = X_W'(quo);
        quo61 = (quo_x << 6) - (quo_x << 1) - quo_x;
        rem_x = x - quo61;
    end

    // Pass the remainder down, keep the quotient chunk in place
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            vld_reg <= tok_in.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            chunk_reg <= load_chunk;
        end
        else if (advance && tok_in.vld)
        begin
            chunk_reg <= quo;
        end
        if (advance && tok_in.vld)
        begin
            last_reg <= tok_in.last;
            rem_reg  <= rem_x[b61e_pkg::DIG_W-1:0];
        end
    end

    assign tok_out = {vld_reg, last_reg, rem_reg};

endmodule

`default_nettype wire

>>> design/b61e_back.sv
`default_nettype none

`include "base61_word_encoder_core_defines.svh"

module b61e_back #(
    parameter int OUT_DEPTH = b61e_pkg::OUT_DEPTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           item_valid,
    input  wire b61e_pkg::item_t                item,
    output logic                                item_pop,
    output logic                                empty,
    input  wire logic                           pop,
    output logic [b61e_pkg::CHAR_W-1:0]         out_char,
    output logic                                last_char
);

    localparam int NC    = b61e_pkg::NUM_CELLS;
    localparam int PTR_W = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;
    localparam int CNT_W = $clog2(OUT_DEPTH + 1);

    logic                          busy_reg, busy_next;
    logic [b61e_pkg::DCNT_W-1:0]   issue_cnt_reg, issue_cnt_next;

    b61e_pkg::tok_t                tok [NC + 1];
    logic [NC-1:0]                 tok_vld_vec;
    logic [NC-1:0]                 last_vec;
    logic                          any_tok;
    logic                          advance;

    b61e_pkg::out_entry_t          oq_mem_reg [OUT_DEPTH];
    logic [PTR_W-1:0]              oq_wr_ptr_reg, oq_wr_ptr_next;
    logic [PTR_W-1:0]              oq_rd_ptr_reg, oq_rd_ptr_next;
    logic [CNT_W-1:0]              oq_count_reg, oq_count_next;
    logic                          oq_wr;
    logic                          oq_rd;
    b61e_pkg::out_entry_t          oq_head;

    // Freeze the chain while the result queue is full
    assign advance  = (oq_count_reg != CNT_W'(OUT_DEPTH));
    assign item_pop = !busy_reg && item_valid;

    // Issue one token per digit into the first cell
    always_comb
    begin
        tok[0].vld  = (issue_cnt_reg != '0);
        tok[0].last = (issue_cnt_reg == b61e_pkg::DCNT_W'(1));
        tok[0].rem  = '0;
    end

    // Cell chain, most significant chunk first
    for (genvar s = 0; s < NC; s++)
    begin : g_cell
        b61e_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .advance    (advance),
            .load       (item_pop),
            .load_chunk (item.value[b61e_pkg::WORD_W - 1 - s * b61e_pkg::CHUNK_W -:
                                    b61e_pkg::CHUNK_W]),
            .tok_in     (tok[s]),
            .tok_out    (tok[s + 1])
        );
        assign tok_vld_vec[s] = tok[s + 1].vld;
        assign last_vec[s]    = tok[s + 1].vld && tok[s + 1].last;
    end

    assign any_tok = |tok_vld_vec;

    // Sequence one word at a time through the chain
    always_comb
    begin
        busy_next      = busy_reg;
        issue_cnt_next = issue_cnt_reg;
        if (item_pop)
        begin
            busy_next      = 1'b1;
            issue_cnt_next = item.ndig;
        end
        else if (busy_reg)
        begin
            if (advance && issue_cnt_reg != '0)
            begin
                issue_cnt_next = issue_cnt_reg - 1'b1;
            end
            if (issue_cnt_reg == '0 && !any_tok)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            issue_cnt_reg <= '0;
        end
        else
        begin
            busy_reg      <= busy_next;
            issue_cnt_reg <= issue_cnt_next;
        end
    end

    // Result queue: digits from the last cell, mapped to characters
    assign oq_wr   = advance && tok[NC].vld;
    assign oq_rd   = pop && !empty;
    assign empty   = (oq_count_reg == '0);
    assign oq_head = oq_mem_reg[oq_rd_ptr_reg];
    assign out_char  = oq_head.ch;
    assign last_char = oq_head.last;

    always_comb
    begin
        oq_wr_ptr_next = oq_wr_ptr_reg;
        oq_rd_ptr_next = oq_rd_ptr_reg;
        oq_count_next  = oq_count_reg;
        if (oq_wr)
        begin
            oq_wr_ptr_next = (oq_wr_ptr_reg == PTR_W'(OUT_DEPTH - 1)) ? '0 :
                             oq_wr_ptr_reg + 1'b1;
        end
        if (oq_rd)
        begin
            oq_rd_ptr_next = (oq_rd_ptr_reg == PTR_W'(OUT_DEPTH - 1)) ? '0 :
                             oq_rd_ptr_reg + 1'b1;
        end
        if (oq_wr && !oq_rd)
        begin
            oq_count_next = oq_count_reg + 1'b1;
        end
        else if (oq_rd && !oq_wr)
        begin
            oq_count_next = oq_count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_wr_ptr_reg <= '0;
            oq_rd_ptr_reg <= '0;
            oq_count_reg  <= '0;
        end
        else
        begin
            oq_wr_ptr_reg <= oq_wr_ptr_next;
            oq_rd_ptr_reg <= oq_rd_ptr_next;
            oq_count_reg  <= oq_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (oq_wr)
        begin
            oq_mem_reg[oq_wr_ptr_reg].ch   <= b61e_pkg::digit_char(tok[NC].rem);
            oq_mem_reg[oq_wr_ptr_reg].last <= tok[NC].last;
        end
    end

    `B61E_ASSERT_IMPL(a_back_tok_needs_busy, any_tok || issue_cnt_reg != '0, busy_reg,
        "digit in flight while idle")
    `B61E_ASSERT_ALWAYS(a_back_one_last, $countones(last_vec) <= 1,
        "two word ends in the cell chain")
    `B61E_ASSERT_NEXT(a_back_stall_holds, !advance && !item_pop,
        $stable(tok_vld_vec) && $stable(issue_cnt_reg), "cell chain moved while stalled")
    `B61E_ASSERT_IMPL(a_back_load_when_drained, item_pop,
        !any_tok && issue_cnt_reg == '0, "word loaded over a busy chain")

endmodule

`default_nettype wire

>>> test/tb.sv
`default_nettype none

module tb;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 40;
    localparam int IDLE_PCT    = 13;

    // Digit characters, most significant position holds digit 0
    localparam bit [8*61-1:0] DIGIT_CHARS =
        "y7kXV05JFpHzRL48QYmbhSjufB2WsD1en9MTgPCxwKldqt6EOUIANa3Gvirco";

    typedef struct {
        logic [7:0] ch;
        logic       last;
    } char_rec_t;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [63:0] word_value;
    logic [1:0]  size_code;
    logic        empty;
    logic        pop;
    logic [7:0]  out_char;
    logic        last_char;

    char_rec_t   pending_chars[$];
    int          mismatch_count;
    int          words_sent;
    int          ignored_sent;
    int          chars_checked;
    int          cycle_count;
    bit          no_stall;

    base61_word_encoder_core u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .word_value (word_value),
        .size_code  (size_code),
        .empty      (empty),
        .pop        (pop),
        .out_char   (out_char),
        .last_char  (last_char)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Print one line per mismatch and count it
    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("MISMATCH at cycle %0d: %s", cycle_count, what);
    endtask

    // Queue the characters that one word encodes to
    function automatic void predict_encoding(input logic [63:0] value, input logic [1:0] code);
        logic [63:0] rest;
        int          ndigits;
        int          digit;
        char_rec_t   rec;
        rest = value;
        case (b61e_pkg::size_code_t'(code))
            b61e_pkg::SIZE_8B: ndigits = 11;
            b61e_pkg::SIZE_4B:
            begin
                ndigits = 6;
                rest = {32'd0, value[31:0]};
            end
            b61e_pkg::SIZE_2B:
            begin
                ndigits = 3;
                rest = {48'd0, value[15:0]};
            end
            default: ndigits = 0;
        endcase
        for (int k = 0; k < ndigits; k++)
        begin
            digit = int'(rest % 64'd61);
            rest = rest / 64'd61;
            rec.ch = DIGIT_CHARS[8*(60-digit) +: 8];
            rec.last = (k == ndigits - 1);
            pending_chars.push_back(rec);
        end
    endfunction

    // Send one word; hold it until the block takes it
    task automatic send_word(input logic [63:0] value, input logic [1:0] code);
        int gap;
        @(negedge clk);
        if (!no_stall && $urandom_range(99) < IDLE_PCT)
        begin
            gap = $urandom_range(1, 4);
            push = 1'b0;
            repeat (gap) @(negedge clk);
        end
        push = 1'b1;
        word_value = value;
        size_code = code;
        do @(posedge clk); while (full);
        predict_encoding(value, code);
        words_sent++;
        if (code == b61e_pkg::SIZE_BAD)
        begin
            ignored_sent++;
        end
    endtask

    // Random content, sometimes small to force leading zero digits
    function automatic logic [63:0] random_word();
        logic [63:0] v;
        v = {$urandom, $urandom};
        if ($urandom_range(7) == 0)
        begin
            v = v % 64'(($urandom_range(3) == 0) ? 61 : 3721);
        end
        return v;
    endfunction

    function automatic logic [1:0] random_code();
        int pick;
        pick = $urandom_range(99);
        if (pick < 5)
        begin
            return b61e_pkg::SIZE_BAD;
        end
        return (pick < 40) ? b61e_pkg::SIZE_8B :
               ((pick < 70) ? b61e_pkg::SIZE_4B : b61e_pkg::SIZE_2B);
    endfunction

    // Extremes, digit boundaries, ignored upper bits and the unused size code
    task automatic test_directed();
        logic [63:0] p61;
        send_word(64'd0, b61e_pkg::SIZE_8B);
        send_word(64'hFFFF_FFFF_FFFF_FFFF, b61e_pkg::SIZE_8B);
        send_word(64'd0, b61e_pkg::SIZE_4B);
        send_word(64'h0000_0000_FFFF_FFFF, b61e_pkg::SIZE_4B);
        send_word(64'd0, b61e_pkg::SIZE_2B);
        send_word(64'h0000_0000_0000_FFFF, b61e_pkg::SIZE_2B);
        p61 = 64'd1;
        repeat (10) p61 = p61 * 64'd61;
        send_word(p61 - 64'd1, b61e_pkg::SIZE_8B);
        send_word(p61, b61e_pkg::SIZE_8B);
        send_word(64'd844596300, b61e_pkg::SIZE_4B);
        send_word(64'd844596301, b61e_pkg::SIZE_4B);
        send_word(64'd3720, b61e_pkg::SIZE_2B);
        send_word(64'd3721, b61e_pkg::SIZE_2B);
        send_word(64'hFFFF_FFFF_0000_0001, b61e_pkg::SIZE_4B);
        send_word(64'hDEAD_BEEF_CAFE_1234, b61e_pkg::SIZE_2B);
        send_word(64'hFFFF_FFFF_FFFF_FFFF, b61e_pkg::SIZE_2B);
        send_word(64'hAAAA_AAAA_AAAA_AAAA, b61e_pkg::SIZE_8B);
        send_word(64'h5555_5555_5555_5555, b61e_pkg::SIZE_8B);
        send_word(64'hFFFF_FFFF_FFFF_FFFF, b61e_pkg::SIZE_BAD);
        send_word(64'd0, b61e_pkg::SIZE_BAD);
        send_word(64'd60, b61e_pkg::SIZE_8B);
    endtask

    // Random words with random idling on both sides
    task automatic test_random_mixed(input int count);
        repeat (count) send_word(random_word(), random_code());
    endtask

    // Back-to-back words with no idling at all
    task automatic test_back_to_back(input int count);
        no_stall = 1'b1;
        repeat (count) send_word(random_word(), random_code());
        no_stall = 1'b0;
    endtask

    // Drive pop with random stalls
    always @(negedge clk)
    begin
        pop <= no_stall || ($urandom_range(99) >= IDLE_PCT);
    end

    // Compare each character transaction with the oldest prediction
    always @(posedge clk)
    begin
        char_rec_t want;
        if (rst_n && pop && !empty)
        begin
            chars_checked++;
            if (pending_chars.size() == 0)
            begin
                report_mismatch($sformatf("unexpected character 0x%02h", out_char));
            end
            else
            begin
                want = pending_chars.pop_front();
                if (out_char !== want.ch)
                begin
                    report_mismatch($sformatf("out_char 0x%02h, want 0x%02h",
                        out_char, want.ch));
                end
                if (last_char !== want.last)
                begin
                    report_mismatch($sformatf("last_char %b, want %b",
                        last_char, want.last));
                end
            end
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        word_value = '0;
        size_code = '0;
        no_stall = 1'b0;
        mismatch_count = 0;
        words_sent = 0;
        ignored_sent = 0;
        chars_checked = 0;
        cycle_count = 0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random_mixed(200);
        test_back_to_back(120);
        test_random_mixed(30);

        // Drain, then keep checking for any characters beyond the predicted ones
        @(negedge clk);
        push = 1'b0;
        while (pending_chars.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Sent %0d words (%0d with the unused size code), checked %0d characters",
            words_sent, ignored_sent, chars_checked);
        $display("All sizes, extremes, digit boundaries and back-to-back traffic covered");
        if (mismatch_count == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

`default_nettype wire
